### sv/edclf_pkg.sv
`default_nettype none
package edclf_pkg;

  localparam int unsigned MAX_BINS_DEF = 1024;

  // config register widths and reset values
  localparam int unsigned DUR_W          = 20;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam logic [19:0] BIN_DUR_RST    = 20'd10000;
  localparam logic [15:0] FIT_LOW_RST    = 16'hD800;  // -10240
  localparam logic [15:0] FIT_HIGH_RST   = 16'hF800;  // -2048
  localparam logic [31:0] MIN_TOT_RST    = 32'd429497;

  localparam int unsigned FRAC_W         = 16;        // log2 fraction bits
  localparam int unsigned LOG10_2_Q16    = 19728;
  localparam int unsigned LOG_ROUND      = 32'h0008_0000;
  localparam int unsigned LOG_SHIFT      = 20;
  localparam logic [15:0] LOG_FLOOR_MAG  = 16'd32768;
  localparam int unsigned DECAY_SCALE    = 24576;     // 6 * 4096
  localparam int unsigned DECAY_SCALE_W  = 15;
  localparam int unsigned MS_SCALE       = 1000;
  localparam int unsigned DIV_STEPS      = 17;
  localparam int unsigned DIV_CNT_W      = 5;

  typedef enum logic [1:0] {
    CFG_BIN_DUR  = 2'd0,
    CFG_FIT_LOW  = 2'd1,
    CFG_FIT_HIGH = 2'd2,
    CFG_MIN_TOT  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_LOW  = 2'd1,
    STAT_FLAT = 2'd2
  } stat_e;

  typedef enum logic [3:0] {
    ST_LOAD, ST_CHECK, ST_LOGT, ST_RD, ST_ACC, ST_LOGC, ST_SCALE,
    ST_WIN, ST_MUL, ST_MWAIT, ST_EVAL, ST_DIV, ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    MS_NXY, MS_XY, MS_NXX, MS_XX, MS_DK, MS_NK
  } mstep_e;

  typedef enum logic [1:0] {
    LG_IDLE, LG_NORM, LG_FRAC
  } lstate_e;

endpackage
`default_nettype wire

### sv/edclf_log2.sv
`default_nettype none
module edclf_log2 #(
  parameter int unsigned VW = 42
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       start_i,
  input  wire logic [VW-1:0]                              val_i,
  output logic                                            busy_o,
  output logic                                            done_o,
  output logic [$clog2(VW)+edclf_pkg::FRAC_W-1:0]         res_o
);
  import edclf_pkg::*;

  localparam int unsigned LZW = $clog2(VW);
  localparam int unsigned FCW = $clog2(FRAC_W);

  lstate_e            st_q, st_d;
  logic [VW-1:0]      v_q, v_d;
  logic [LZW-1:0]     lz_q, lz_d;
  logic [LZW-1:0]     k_q;
  logic [FCW-1:0]     f_q;
  logic [31:0]        m_q;
  logic [FRAC_W-1:0]  fr_q;
  logic               done_q;
  logic [LZW+FRAC_W-1:0] res_q;

  logic [LZW-1:0]     sh;
  logic [VW-1:0]      hi_mask;
  logic [63:0]        sq;
  logic [32:0]        t;

  always_comb begin
    sh      = LZW'(1) << (LZW'(LZW-1) - k_q);
    hi_mask = ~({VW{1'b1}} >> sh);
    if ((v_q & hi_mask) == '0) begin
      v_d  = v_q << sh;
      lz_d = lz_q + sh;
    end else begin
      v_d  = v_q;
      lz_d = lz_q;
    end
    sq = m_q * m_q;
    t  = sq[63:31];
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      LG_IDLE: if (start_i) st_d = LG_NORM;
      LG_NORM: if (k_q == LZW'(LZW-1)) st_d = LG_FRAC;
      LG_FRAC: if (f_q == FCW'(FRAC_W-1)) st_d = LG_IDLE;
      default: st_d = LG_IDLE;
    endcase
  end

  always_comb begin
    busy_o = (st_q != LG_IDLE);
    done_o = done_q;
    res_o  = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= LG_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == LG_FRAC) && (f_q == FCW'(FRAC_W-1));
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      LG_IDLE: begin
        v_q  <= val_i;
        lz_q <= '0;
        k_q  <= '0;
        f_q  <= '0;
      end
      LG_NORM: begin
        v_q  <= v_d;
        lz_q <= lz_d;
        k_q  <= k_q + LZW'(1);
        m_q  <= v_d[VW-1 -: 32];
      end
      LG_FRAC: begin
        m_q  <= t[32] ? t[32:1] : t[31:0];
        fr_q <= {fr_q[FRAC_W-2:0], t[32]};
        f_q  <= f_q + FCW'(1);
        if (f_q == FCW'(FRAC_W-1)) begin
          res_q <= {LZW'(VW-1) - lz_q, fr_q[FRAC_W-2:0], t[32]};
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### sv/edclf_mul.sv
`default_nettype none
module edclf_mul #(
  parameter int unsigned OW = 46
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [OW-1:0]     a_i,
  input  wire logic [OW-1:0]     b_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [2*OW-1:0]        prod_o
);

  localparam int unsigned CNW = $clog2(OW+1);

  logic            busy_q, done_q;
  logic [CNW-1:0]  cnt_q;
  logic [OW-1:0]   a_q, b_q, hi_q, lo_q;
  logic [OW:0]     sum;

  // shift-add, one multiplier bit per cycle, LSB first
  assign sum    = {1'b0, hi_q} + (b_q[0] ? {1'b0, a_q} : '0);
  assign busy_o = busy_q;
  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNW'(1);
        if (cnt_q == CNW'(OW-1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      a_q  <= a_i;
      b_q  <= b_i;
      hi_q <= '0;
      lo_q <= '0;
    end else if (busy_q) begin
      hi_q <= sum[OW:1];
      lo_q <= {sum[0], lo_q[OW-1:1]};
      b_q  <= b_q >> 1;
    end
  end

endmodule
`default_nettype wire

### sv/edc_line_fit_reverb_time.sv
// Bins are taken one per cycle while loading; each is weighted, registered, then stored and summed.
// After the last bin the total's log2 is taken unless the total is too low; a backward pass over
// the stored bins then reads each, runs the log2 unit (log2(VW) normalize steps and 16 squaring
// steps) unless its curve point is 0, and updates the fit; then up to six multiplies and a divide.
// One histogram is worked at a time; its result waits in an output register.
// Reset clears control state, totals and config; the bin memory is not cleared.
`default_nettype none
module edc_line_fit_reverb_time #(
  parameter int unsigned MAX_BINS = edclf_pkg::MAX_BINS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [edclf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [edclf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [31:0]                       bin_energy_i,
  input  wire logic [15:0]                       absorption_weight_i,
  input  wire logic                              last_bin_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [15:0]                            decay_ms_o,
  output logic [1:0]                             status_o
);
  import edclf_pkg::*;

  localparam int unsigned XW   = $clog2(MAX_BINS);
  localparam int unsigned CW   = $clog2(MAX_BINS+1);
  localparam int unsigned VW   = 32 + XW;
  localparam int unsigned LRW  = $clog2(VW) + FRAC_W;
  localparam int unsigned SXW  = 2*XW;
  localparam int unsigned SXXW = 3*XW;
  localparam int unsigned SYW  = XW + 16;
  localparam int unsigned SXYW = 2*XW + 15;
  localparam int unsigned NW   = 3*XW + 16;
  localparam int unsigned DW   = 4*XW + 1;
  localparam int unsigned KW   = DUR_W + DECAY_SCALE_W;
  localparam int unsigned OW0  = (DW > NW) ? DW : NW;
  localparam int unsigned OW   = (OW0 > KW) ? OW0 : KW;
  localparam int unsigned PW   = 2*OW;
  localparam int unsigned QW   = PW + DIV_STEPS;
  localparam int unsigned SCW  = LRW + 16;

  // config
  logic [DUR_W-1:0]   bdu_q;
  logic signed [15:0] flo_q, fhi_q;
  logic [31:0]        mtot_q;

  // control
  state_e             state_q, state_d;
  mstep_e             mstep_q;
  logic [CW-1:0]      count_q, i_q, ipm1;
  logic               stg_q, lastp_q, wr_q;
  logic [XW-1:0]      widx_q;
  logic [31:0]        wdat_q;
  logic [VW-1:0]      tot_q, curve_q, curve_d;
  logic [DIV_CNT_W-1:0] dcnt_q;

  // memory
  logic [31:0]        bins_mem [MAX_BINS];
  logic [31:0]        rd_q;
  logic               mem_re;

  // fit accumulators (magnitudes: every y is <= 0)
  logic [LRW-1:0]     ltot_q, mag_q;
  logic [15:0]        ny_q;
  logic [SXW-1:0]     sx_q;
  logic [SXXW-1:0]    sxx_q;
  logic [SYW-1:0]     sny_q;
  logic [SXYW-1:0]    snxy_q;
  logic [CW-1:0]      fitn_q;

  // final arithmetic
  logic [PW-1:0]      p1_q, rem_q;
  logic [OW-1:0]      nmag_q, den_q;
  logic               nneg_q, nzero_q;
  logic [QW-1:0]      dsh_q;
  logic [DIV_STEPS-1:0] qt_q;
  logic [15:0]        rdec_q, dec_q;
  stat_e              rstat_q, stat_q;
  logic               out_valid_q;

  // units
  logic               log_start, log_busy, log_done;
  logic [VW-1:0]      log_val;
  logic [LRW-1:0]     log_res;
  logic               mul_start, mul_busy, mul_done;
  logic [OW-1:0]      mul_a, mul_b;
  logic [PW-1:0]      mul_p;

  logic               accept, out_free, low_tot, in_win, div_ge;
  logic [47:0]        wprod;
  logic [32:0]        wsh;
  logic [31:0]        wsat;
  logic [SCW-1:0]     sc, yv;
  logic [15:0]        ny_d;
  logic signed [16:0] ys, lo17, hi17;
  logic [XW-1:0]      xv;
  logic [KW-1:0]      kval;

  edclf_log2 #(.VW(VW)) u_log (
    .clk_i, .rst_ni, .start_i(log_start), .val_i(log_val),
    .busy_o(log_busy), .done_o(log_done), .res_o(log_res)
  );

  edclf_mul #(.OW(OW)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .busy_o(mul_busy), .done_o(mul_done), .prod_o(mul_p)
  );

  always_comb begin
    accept   = in_valid_i && in_ready_o;
    out_free = !out_valid_q || out_ready_i;
    wprod    = bin_energy_i * absorption_weight_i;
    wsh      = wprod[47:15];
    wsat     = wsh[32] ? 32'hFFFF_FFFF : wsh[31:0];
    low_tot  = (tot_q == '0) || (tot_q < VW'(mtot_q));
    curve_d  = curve_q + VW'(rd_q);
    ipm1     = i_q - CW'(1);
    xv       = ipm1[XW-1:0];
    sc       = SCW'(mag_q) * SCW'(LOG10_2_Q16) + SCW'(LOG_ROUND);
    yv       = sc >> LOG_SHIFT;
    ny_d     = (yv >= SCW'(LOG_FLOOR_MAG)) ? LOG_FLOOR_MAG : yv[15:0];
    ys       = 17'sd0 - $signed({1'b0, ny_q});
    lo17     = flo_q;
    hi17     = fhi_q;
    in_win   = (lo17 <= ys) && (ys <= hi17);
    kval     = KW'(bdu_q) * KW'(DECAY_SCALE);
    div_ge   = {{DIV_STEPS{1'b0}}, rem_q} >= dsh_q;
    log_val  = (state_q == ST_CHECK) ? tot_q : curve_d;
    case (mstep_q)
      MS_NXY:  begin mul_a = OW'(fitn_q); mul_b = OW'(snxy_q); end
      MS_XY:   begin mul_a = OW'(sx_q);   mul_b = OW'(sny_q);  end
      MS_NXX:  begin mul_a = OW'(fitn_q); mul_b = OW'(sxx_q);  end
      MS_XX:   begin mul_a = OW'(sx_q);   mul_b = OW'(sx_q);   end
      MS_DK:   begin mul_a = den_q;       mul_b = OW'(kval);   end
      MS_NK:   begin mul_a = nmag_q;      mul_b = OW'(MS_SCALE); end
      default: begin mul_a = '0;          mul_b = '0;          end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:  if (stg_q && lastp_q) state_d = ST_CHECK;
      ST_CHECK: state_d = low_tot ? ST_OUT : ST_LOGT;
      ST_LOGT:  if (log_done) state_d = ST_RD;
      ST_RD:    state_d = ST_ACC;
      ST_ACC:   state_d = (curve_d == '0) ? ST_WIN : ST_LOGC;
      ST_LOGC:  if (log_done) state_d = ST_SCALE;
      ST_SCALE: state_d = ST_WIN;
      ST_WIN:   state_d = (i_q == CW'(1)) ? ST_MUL : ST_RD;
      ST_MUL:   state_d = ST_MWAIT;
      ST_MWAIT: begin
        if (mul_done) begin
          case (mstep_q)
            MS_XX:   state_d = ST_EVAL;
            MS_NK:   state_d = ST_DIV;
            default: state_d = ST_MUL;
          endcase
        end
      end
      ST_EVAL:  state_d = (nzero_q || !nneg_q || den_q == '0) ? ST_OUT : ST_MUL;
      ST_DIV:   if (dcnt_q == DIV_CNT_W'(DIV_STEPS-1)) state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_LOAD;
      default:  state_d = ST_LOAD;
    endcase
  end

  // unit and port controls
  always_comb begin
    in_ready_o = (state_q == ST_LOAD) && !lastp_q;
    log_start  = ((state_q == ST_CHECK) && !low_tot) ||
                 ((state_q == ST_ACC) && (curve_d != '0));
    mul_start  = (state_q == ST_MUL);
    mem_re     = (state_q == ST_RD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      mstep_q     <= MS_NXY;
      count_q     <= '0;
      i_q         <= '0;
      stg_q       <= 1'b0;
      lastp_q     <= 1'b0;
      tot_q       <= '0;
      out_valid_q <= 1'b0;
      bdu_q       <= BIN_DUR_RST;
      flo_q       <= FIT_LOW_RST;
      fhi_q       <= FIT_HIGH_RST;
      mtot_q      <= MIN_TOT_RST;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_BIN_DUR:  bdu_q  <= cfg_data_i[DUR_W-1:0];
          CFG_FIT_LOW:  flo_q  <= cfg_data_i[15:0];
          CFG_FIT_HIGH: fhi_q  <= cfg_data_i[15:0];
          CFG_MIN_TOT:  mtot_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_ready_i) out_valid_q <= 1'b0;
      stg_q <= accept;
      if (accept) begin
        lastp_q <= last_bin_i;
        if (count_q < CW'(MAX_BINS)) count_q <= count_q + CW'(1);
      end
      if (stg_q && wr_q) tot_q <= tot_q + VW'(wdat_q);
      if (state_q == ST_LOAD && stg_q && lastp_q) begin
        i_q     <= count_q;
        count_q <= '0;
        lastp_q <= 1'b0;
      end
      if (state_q == ST_WIN) i_q <= ipm1;
      if (state_q == ST_CHECK) mstep_q <= MS_NXY;
      if (state_q == ST_MWAIT && mul_done) begin
        case (mstep_q)
          MS_NXY:  mstep_q <= MS_XY;
          MS_XY:   mstep_q <= MS_NXX;
          MS_NXX:  mstep_q <= MS_XX;
          MS_XX:   mstep_q <= MS_DK;
          MS_DK:   mstep_q <= MS_NK;
          default: mstep_q <= MS_NXY;
        endcase
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
        tot_q       <= '0;
      end
    end
  end

  // bin memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (stg_q && wr_q) bins_mem[widx_q] <= wdat_q;
    if (mem_re) rd_q <= bins_mem[ipm1[XW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      wr_q   <= (count_q < CW'(MAX_BINS));
      widx_q <= count_q[XW-1:0];
      wdat_q <= wsat;
    end
    case (state_q)
      ST_CHECK: begin
        curve_q <= '0;
        sx_q    <= '0;
        sxx_q   <= '0;
        sny_q   <= '0;
        snxy_q  <= '0;
        fitn_q  <= '0;
        rdec_q  <= '0;
        rstat_q <= low_tot ? STAT_LOW : STAT_OK;
      end
      ST_LOGT:  if (log_done) ltot_q <= log_res;
      ST_ACC: begin
        curve_q <= curve_d;
        ny_q    <= LOG_FLOOR_MAG;
      end
      ST_LOGC:  if (log_done) mag_q <= ltot_q - log_res;
      ST_SCALE: ny_q <= ny_d;
      ST_WIN: begin
        if (in_win) begin
          sx_q   <= sx_q + SXW'(xv);
          sxx_q  <= sxx_q + SXXW'(xv * xv);
          sny_q  <= sny_q + SYW'(ny_q);
          snxy_q <= snxy_q + SXYW'(xv * ny_q);
          fitn_q <= fitn_q + CW'(1);
        end
      end
      ST_MWAIT: begin
        if (mul_done) begin
          case (mstep_q)
            MS_NXY, MS_NXX: p1_q <= mul_p;
            MS_XY: begin
              // num = sum_x*|sum_y| - N*|sum_xy|
              nneg_q  <= p1_q > mul_p;
              nzero_q <= p1_q == mul_p;
              nmag_q  <= OW'(p1_q - mul_p);
            end
            MS_XX:  den_q <= OW'(p1_q - mul_p);
            MS_DK:  rem_q <= mul_p;
            MS_NK: begin
              dsh_q  <= QW'({mul_p, {(DIV_STEPS-1){1'b0}}});
              qt_q   <= '0;
              dcnt_q <= '0;
            end
            default: ;
          endcase
        end
      end
      ST_EVAL:  if (nzero_q) rstat_q <= STAT_FLAT;
      ST_DIV: begin
        if (div_ge) rem_q <= rem_q - dsh_q[PW-1:0];
        qt_q   <= {qt_q[DIV_STEPS-2:0], div_ge};
        dsh_q  <= dsh_q >> 1;
        dcnt_q <= dcnt_q + DIV_CNT_W'(1);
        if (dcnt_q == DIV_CNT_W'(DIV_STEPS-1)) begin
          rdec_q <= qt_q[DIV_STEPS-2] ? 16'hFFFF : {qt_q[14:0], div_ge};
        end
      end
      ST_OUT: begin
        if (out_free) begin
          dec_q  <= rdec_q;
          stat_q <= rstat_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign decay_ms_o  = dec_q;
  assign status_o    = stat_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_BINS))
    else $error("bin count beyond capacity");
  a_log_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    log_start |-> !log_busy)
    else $error("log2 unit started while busy");
  a_mul_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_busy)
    else $error("multiplier started while busy");
  a_flat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STAT_OK) |-> decay_ms_o == '0)
    else $error("nonzero decay with error status");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> !in_ready_o && !stg_q)
    else $error("item taken during fit");
`endif

endmodule
`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
module tb;
  import edclf_pkg::*;

  localparam int unsigned NBINS = 1024;
  localparam int unsigned STALL_LIMIT = 200000;

  typedef struct packed {
    logic [15:0] decay_ms;
    stat_e       status;
  } fit_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] bin_energy_i = '0;
  logic [15:0] absorption_weight_i = '0;
  logic        last_bin_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] decay_ms_o;
  logic [1:0]  status_o;

  edc_line_fit_reverb_time u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] bin_store [NBINS];
  int unsigned bins_held;
  longint unsigned energy_total;
  logic [19:0] dur_us;
  int          win_low, win_high;
  logic [31:0] energy_floor;

  fit_result_t decay_queue[$];
  int          errors = 0;
  int          n_items = 0, n_results = 0, n_hist = 0, n_cfg = 0;
  int          stat_seen[3] = '{0, 0, 0};
  bit          quiet = 1'b0;
  int          idle_cycles = 0;
  int          out_stall = 0;

  function automatic longint unsigned log2_fix(longint unsigned v);
    int e;
    longint unsigned m, frac;
    e = 63;
    frac = 0;
    while (e > 0 && v[e] == 1'b0) e--;
    m = (e >= 31) ? (v >> (e - 31)) : (v << (31 - e));
    for (int k = 15; k >= 0; k--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac |= 64'd1 << k;
      end
    end
    return (longint'(e) << 16) | frac;
  endfunction

  function automatic int curve_log10(longint unsigned curve, longint unsigned tot);
    longint unsigned mag, y;
    if (curve == 0) return -32768;
    mag = log2_fix(tot) - log2_fix(curve);
    y = (mag * LOG10_2_Q16 + (64'd1 << 19)) >> 20;
    if (y >= 32768) return -32768;
    return -int'(y);
  endfunction

  function automatic logic [15:0] ms_from_fit(longint unsigned den, longint unsigned nb,
                                              longint unsigned d);
    logic [127:0] lhs, rhs;
    logic [15:0]  r;
    logic [15:0]  c;
    lhs = 128'(den) * 128'(nb);
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      c = r | (16'd1 << b);
      rhs = 128'(d) * (128'(c) * 128'd1000);
      if (lhs >= rhs) r = c;
    end
    return r;
  endfunction

  function automatic fit_result_t close_histogram();
    fit_result_t     res;
    longint unsigned curve;
    longint          sx, sy, sxx, sxy, num, den, pts;
    int              y;
    res.decay_ms = '0;
    res.status = STAT_OK;
    curve = 0;
    sx = 0; sy = 0; sxx = 0; sxy = 0; pts = 0;
    if (energy_total == 0 || energy_total < 64'(energy_floor)) begin
      res.status = STAT_LOW;
    end else begin
      for (int i = int'(bins_held) - 1; i >= 0; i--) begin
        curve += bin_store[i];
        y = curve_log10(curve, energy_total);
        if (win_low <= y && y <= win_high) begin
          sx += i;
          sy += y;
          sxx += longint'(i) * i;
          sxy += longint'(i) * y;
          pts++;
        end
      end
      num = pts * sxy - sx * sy;
      den = pts * sxx - sx * sx;
      if (num == 0) res.status = STAT_FLAT;
      else if (num < 0 && den > 0)
        res.decay_ms = ms_from_fit(den, 64'd24576 * dur_us, -num);
    end
    return res;
  endfunction

  function automatic void take_bin(logic [31:0] e, logic [15:0] w, logic last);
    longint unsigned p;
    if (bins_held < NBINS) begin
      p = (64'(e) * 64'(w)) >> 15;
      if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
      bin_store[bins_held] = p[31:0];
      energy_total += p;
      bins_held++;
    end
    if (last) begin
      decay_queue.push_back(close_histogram());
      bins_held = 0;
      energy_total = 0;
      n_hist++;
    end
  endfunction

  task automatic send_bin(logic [31:0] e, logic [15:0] w, logic last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    bin_energy_i <= e;
    absorption_weight_i <= w;
    last_bin_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    take_bin(e, w, last);
    n_items++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (decay_queue.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BIN_DUR:  dur_us = val[19:0];
      CFG_FIT_LOW:  win_low = int'(signed'(val[15:0]));
      CFG_FIT_HIGH: win_high = int'(signed'(val[15:0]));
      CFG_MIN_TOT:  energy_floor = val;
      default: ;
    endcase
    n_cfg++;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [19:0] d, logic signed [15:0] lo, logic signed [15:0] hi,
                            logic [31:0] floor_e);
    drain();
    write_reg(CFG_BIN_DUR, {12'(0), d});
    write_reg(CFG_FIT_LOW, {{16{lo[15]}}, lo});
    write_reg(CFG_FIT_HIGH, {{16{hi[15]}}, hi});
    write_reg(CFG_MIN_TOT, floor_e);
  endtask

  // decaying histogram with random content; shift grows with bin index
  task automatic send_decay(int len, int rate, logic [31:0] start, bit wide_w);
    logic [31:0] e;
    logic [15:0] w;
    int sh;
    for (int i = 0; i < len; i++) begin
      sh = (i * rate) >> 3;
      e = (sh > 31) ? 32'd0 : (start >> sh);
      e = e ^ ($urandom() & (e >> 3));
      if ($urandom_range(0, 19) == 0) e = $urandom();
      w = wide_w ? 16'($urandom()) : 16'($urandom_range(16384, 32768));
      send_bin(e, w, i == len - 1);
    end
  endtask

  task automatic test_directed();
    send_decay(8, 8, 32'hFFFF_FFFF, 1'b0);
    send_bin(32'hFFFF_FFFF, 16'hFFFF, 1'b1);        // single bin, weight above one
    send_bin(32'd0, 16'd32768, 1'b0);               // too little energy
    send_bin(32'd0, 16'd0, 1'b1);
    send_bin(32'hFFFF_FFFF, 16'd32768, 1'b0);       // trailing zero curve points
    send_bin(32'h0000_0001, 16'd32768, 1'b0);       // deep log saturation
    send_bin(32'd0, 16'd32768, 1'b0);
    send_bin(32'd0, 16'd1, 1'b1);
    send_decay(6, 12, 32'h8000_0000, 1'b1);
    send_bin(32'h5555_5555, 16'h5555, 1'b0);
    send_bin(32'hAAAA_AAAA, 16'hAAAA, 1'b1);
  endtask

  task automatic test_config_sweep();
    set_config(20'd0, -16'sd32768, 16'sd0, 32'd0);         // zero duration
    send_decay(10, 6, 32'hF000_0000, 1'b0);
    set_config(20'd1, -16'sd32768, 16'sd0, 32'hFFFF_FFFF);  // threshold at max
    send_decay(5, 8, 32'hFFFF_FFFF, 1'b0);
    send_decay(4, 8, 32'h0000_FFFF, 1'b0);
    set_config(20'hFFFFF, -16'sd1000, -16'sd4000, 32'd1);   // empty window
    send_decay(6, 8, 32'hFFFF_FFFF, 1'b0);
    set_config(20'd1000000, -16'sd32768, 16'sd0, 32'd0);
    send_decay(12, 5, 32'hFFFF_FFFF, 1'b0);
    set_config(20'd10000, -16'sd10240, -16'sd2048, 32'd429497);
  endtask

  task automatic test_random(int n_target);
    int start_n, len;
    start_n = n_items;
    while (n_items - start_n < n_target) begin
      if ($urandom_range(0, 7) == 0) begin
        set_config(($urandom_range(0, 9) == 0) ? 20'($urandom()) : 20'($urandom_range(1, 50000)),
                   16'(-int'($urandom_range(4096, 32768))),
                   16'(-int'($urandom_range(0, 4096))),
                   ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 1000000)));
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(2, 40);
      if ($urandom_range(0, 9) == 0) begin
        for (int i = 0; i < len; i++)
          send_bin($urandom(), 16'($urandom()), i == len - 1);
      end else begin
        send_decay(len, $urandom_range(1, 24), $urandom() | 32'h8000_0000,
                   $urandom_range(0, 4) == 0);
      end
    end
  endtask

  task automatic test_overlong();
    send_decay(NBINS + 6, 1, 32'hFFFF_FFFF, 1'b0);
  endtask

  always @(posedge clk_i) begin
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_stall <= $urandom_range(0, 10);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    fit_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (decay_queue.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: decay_ms %0d status %0d",
                 $time, decay_ms_o, status_o);
      end else begin
        want = decay_queue.pop_front();
        if (status_o <= 2) stat_seen[status_o]++;
        if (decay_ms_o !== want.decay_ms) begin
          errors++;
          $display("%0t: decay_ms expected %0d actual %0d", $time, want.decay_ms, decay_ms_o);
        end
        if (status_o !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    dur_us = BIN_DUR_RST;
    win_low = int'(signed'(FIT_LOW_RST));
    win_high = int'(signed'(FIT_HIGH_RST));
    energy_floor = MIN_TOT_RST;
    bins_held = 0;
    energy_total = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_sweep();
    test_random(600);
    test_overlong();
    drain();                       // sender holds off until every result is back
    test_random(200);
    quiet = 1'b1;
    test_random(100);
    drain();
    repeat (50) @(posedge clk_i);
    if (decay_queue.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, decay_queue.size());
    end
    $display("Ran %0d bins in %0d histograms, %0d register writes, %0d results checked",
             n_items, n_hist, n_cfg, n_results);
    $display("Status mix: ok %0d, low energy %0d, flat %0d; error count %0d",
             stat_seen[0], stat_seen[1], stat_seen[2], errors);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
